@@ design/tcrc_pkg.sv @@
package tcrc_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BitIdxW       = $clog2(BITS_PER_BYTE + 1);
    localparam int TickW         = 24;
    localparam int BitTickW      = 16;
    localparam int ByteW         = 8;
    localparam int CfgIdxW       = 3;
    localparam int CfgDataW      = 24;

    localparam logic [TickW-1:0]    INIT_TICKS_RST   = TickW'(20050);
    localparam logic [TickW-1:0]    CHARGE_TICKS_RST = TickW'(16000000);
    localparam logic [TickW-1:0]    START_TICKS_RST  = TickW'(20000);
    localparam logic [BitTickW-1:0] BIT_TICKS_RST    = BitTickW'(512);
    localparam logic [TickW-1:0]    GAP_TICKS_RST    = TickW'(24000);
    localparam logic [ByteW-1:0]    EXPECTED_RST     = ByteW'(1);

    typedef enum logic [2:0] {
        PH_INIT   = 3'd0,
        PH_CHARGE = 3'd1,
        PH_START  = 3'd2,
        PH_READ   = 3'd3,
        PH_GAP    = 3'd4
    } phase_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_INIT_TICKS   = 3'd0,
        CFG_CHARGE_TICKS = 3'd1,
        CFG_START_TICKS  = 3'd2,
        CFG_BIT_TICKS    = 3'd3,
        CFG_GAP_TICKS    = 3'd4,
        CFG_EXPECTED     = 3'd5
    } cfg_idx_t;

endpackage

@@ design/transponder_charge_read_controller_unit.sv @@
// each accepted input item's result is loaded into the output register
// throughput: one item per cycle; the single output register holds a result while
// the next item is accepted as soon as that result is taken
// reset (rst_n low, async): init phase, counters and bytes cleared, match flag set,
// configuration registers back to their defaults, no result pending
module transponder_charge_read_controller_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [tcrc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [tcrc_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           line_level,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           txct_level,
    output logic                           byte_valid,
    output logic [tcrc_pkg::ByteW-1:0]     byte_value,
    output logic                           frame_done,
    output logic                           auth_ok,
    output logic [tcrc_pkg::ByteW-1:0]     byte_count
);

    logic [tcrc_pkg::TickW-1:0]    init_ticks_reg;
    logic [tcrc_pkg::TickW-1:0]    charge_ticks_reg;
    logic [tcrc_pkg::TickW-1:0]    start_ticks_reg;
    logic [tcrc_pkg::BitTickW-1:0] bit_ticks_reg;
    logic [tcrc_pkg::TickW-1:0]    gap_ticks_reg;
    logic [tcrc_pkg::ByteW-1:0]    expected_reg;

    tcrc_pkg::phase_t              phase_reg, phase_next;
    logic [tcrc_pkg::TickW-1:0]    tick_count_reg, tick_count_next;
    logic [tcrc_pkg::BitIdxW-1:0]  bit_index_reg, bit_index_next;
    logic [tcrc_pkg::ByteW-1:0]    shift_byte_reg, shift_byte_next;
    logic [tcrc_pkg::ByteW-1:0]    bytes_seen_reg, bytes_seen_next;
    logic                          all_match_reg, all_match_next;

    logic                          out_valid_reg;
    logic                          txct_level_reg, txct_level_next;
    logic                          byte_valid_reg, byte_valid_next;
    logic [tcrc_pkg::ByteW-1:0]    byte_value_reg, byte_value_next;
    logic                          frame_done_reg, frame_done_next;
    logic                          auth_ok_reg, auth_ok_next;
    logic [tcrc_pkg::ByteW-1:0]    byte_count_reg, byte_count_next;

    logic                          accept;
    logic [tcrc_pkg::TickW-1:0]    tick_inc;
    logic                          byte_emit;
    logic                          gap_done;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign tick_inc = tick_count_reg + tcrc_pkg::TickW'(1);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_ticks_reg   <= tcrc_pkg::INIT_TICKS_RST;
            charge_ticks_reg <= tcrc_pkg::CHARGE_TICKS_RST;
            start_ticks_reg  <= tcrc_pkg::START_TICKS_RST;
            bit_ticks_reg    <= tcrc_pkg::BIT_TICKS_RST;
            gap_ticks_reg    <= tcrc_pkg::GAP_TICKS_RST;
            expected_reg     <= tcrc_pkg::EXPECTED_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tcrc_pkg::CFG_INIT_TICKS:   init_ticks_reg   <= cfg_data;
                tcrc_pkg::CFG_CHARGE_TICKS: charge_ticks_reg <= cfg_data;
                tcrc_pkg::CFG_START_TICKS:  start_ticks_reg  <= cfg_data;
                tcrc_pkg::CFG_BIT_TICKS:    bit_ticks_reg    <= cfg_data[tcrc_pkg::BitTickW-1:0];
                tcrc_pkg::CFG_GAP_TICKS:    gap_ticks_reg    <= cfg_data;
                tcrc_pkg::CFG_EXPECTED:     expected_reg     <= cfg_data[tcrc_pkg::ByteW-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        bytes_seen_next = bytes_seen_reg;
        all_match_next  = all_match_reg;
        byte_emit       = 1'b0;
        gap_done        = 1'b0;

        case (phase_reg)
            tcrc_pkg::PH_INIT:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= init_ticks_reg)
                begin
                    phase_next      = tcrc_pkg::PH_CHARGE;
                    tick_count_next = '0;
                end
            end
            tcrc_pkg::PH_START:
            begin
                if (line_level)
                begin
                    bytes_seen_next = '0;
                    all_match_next  = 1'b1;
                    phase_next      = tcrc_pkg::PH_READ;
                    shift_byte_next = tcrc_pkg::ByteW'(1);
                    bit_index_next  = tcrc_pkg::BitIdxW'(1);
                    tick_count_next = '0;
                end
                else
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= start_ticks_reg)
                    begin
                        phase_next      = tcrc_pkg::PH_CHARGE;
                        tick_count_next = '0;
                    end
                end
            end
            tcrc_pkg::PH_READ:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= tcrc_pkg::TickW'(bit_ticks_reg))
                begin
                    tick_count_next = '0;
                    if (bit_index_reg < tcrc_pkg::BitIdxW'(tcrc_pkg::BITS_PER_BYTE))
                    begin
                        // samples past the top bit of the byte are dropped
                        if (32'(bit_index_reg) < tcrc_pkg::ByteW)
                        begin
                            shift_byte_next = shift_byte_reg
                                | (tcrc_pkg::ByteW'(line_level) << bit_index_reg);
                        end
                        bit_index_next = bit_index_reg + tcrc_pkg::BitIdxW'(1);
                    end
                    else
                    begin
                        byte_emit = 1'b1;
                        if (bytes_seen_reg != {tcrc_pkg::ByteW{1'b1}})
                        begin
                            bytes_seen_next = bytes_seen_reg + tcrc_pkg::ByteW'(1);
                        end
                        if (shift_byte_reg != expected_reg)
                        begin
                            all_match_next = 1'b0;
                        end
                        phase_next     = tcrc_pkg::PH_GAP;
                        bit_index_next = '0;
                    end
                end
            end
            tcrc_pkg::PH_GAP:
            begin
                if (line_level)
                begin
                    phase_next      = tcrc_pkg::PH_READ;
                    shift_byte_next = tcrc_pkg::ByteW'(1);
                    bit_index_next  = tcrc_pkg::BitIdxW'(1);
                    tick_count_next = '0;
                end
                else
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= gap_ticks_reg)
                    begin
                        gap_done        = 1'b1;
                        phase_next      = tcrc_pkg::PH_CHARGE;
                        tick_count_next = '0;
                        bytes_seen_next = '0;
                        all_match_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                // charge phase, also the fallback for unused codes
                phase_next      = tcrc_pkg::PH_CHARGE;
                tick_count_next = tick_inc;
                if (tick_inc >= charge_ticks_reg)
                begin
                    phase_next      = tcrc_pkg::PH_START;
                    tick_count_next = '0;
                end
            end
        endcase
    end

    // result fields
    always_comb
    begin
        txct_level_next = (phase_reg != tcrc_pkg::PH_CHARGE);
        byte_valid_next = byte_emit;
        byte_value_next = byte_emit ? shift_byte_reg : '0;
        frame_done_next = gap_done;
        auth_ok_next    = gap_done && all_match_reg;
        if (gap_done)
        begin
            byte_count_next = bytes_seen_reg;
        end
        else if (phase_next inside {tcrc_pkg::PH_CHARGE, tcrc_pkg::PH_INIT,
                                    tcrc_pkg::PH_START})
        begin
            byte_count_next = '0;
        end
        else
        begin
            byte_count_next = bytes_seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= tcrc_pkg::PH_INIT;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            shift_byte_reg <= '0;
            bytes_seen_reg <= '0;
            all_match_reg  <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                tick_count_reg <= tick_count_next;
                bit_index_reg  <= bit_index_next;
                shift_byte_reg <= shift_byte_next;
                bytes_seen_reg <= bytes_seen_next;
                all_match_reg  <= all_match_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            txct_level_reg <= txct_level_next;
            byte_valid_reg <= byte_valid_next;
            byte_value_reg <= byte_value_next;
            frame_done_reg <= frame_done_next;
            auth_ok_reg    <= auth_ok_next;
            byte_count_reg <= byte_count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign txct_level = txct_level_reg;
    assign byte_valid = byte_valid_reg;
    assign byte_value = byte_value_reg;
    assign frame_done = frame_done_reg;
    assign auth_ok    = auth_ok_reg;
    assign byte_count = byte_count_reg;

endmodule

@@ design/tcrc_checker.sv @@
module tcrc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           txct_level,
    input  logic                           byte_valid,
    input  logic [tcrc_pkg::ByteW-1:0]     byte_value,
    input  logic                           frame_done,
    input  logic                           auth_ok,
    input  logic [tcrc_pkg::ByteW-1:0]     byte_count
);

    // an empty output register never holds off the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid
            && $stable({txct_level, byte_valid, byte_value, frame_done, auth_ok, byte_count})))
        else $error("stalled result changed");

    // a completed byte is always counted and never seen during charge
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_valid) |-> (byte_count != '0 && txct_level && !frame_done))
        else $error("byte item with bad count or level");

    // the item after a frame end starts charging with an empty count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && frame_done)
            |=> (!out_valid || (!txct_level && byte_count == '0)))
        else $error("frame end not followed by charge");

endmodule

bind transponder_charge_read_controller_unit tcrc_checker u_tcrc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .txct_level (txct_level),
    .byte_valid (byte_valid),
    .byte_value (byte_value),
    .frame_done (frame_done),
    .auth_ok    (auth_ok),
    .byte_count (byte_count)
);

@@ tb/tcrc_checker.sv @@
module tcrc_scoreboard
    import tcrc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                line_level,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                txct_level,
    input  logic                byte_valid,
    input  logic [ByteW-1:0]    byte_value,
    input  logic                frame_done,
    input  logic                auth_ok,
    input  logic [ByteW-1:0]    byte_count,
    output int                  mismatches,
    output int                  pending_results,
    output phase_t              reader_phase,
    output logic [BitIdxW-1:0]  reader_bit,
    output int                  ticks_checked,
    output int                  bytes_read,
    output int                  frames_closed,
    output int                  frames_authorized
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             txct;
        logic             strobe;
        logic [ByteW-1:0] value;
        logic             done;
        logic             auth;
        logic [ByteW-1:0] count;
    } tick_result_t;

    tick_result_t tick_results[$];
    tick_result_t want;

    // configuration copy, tracked from the write port
    int unsigned init_lim, charge_lim, start_lim, bit_lim, gap_lim;
    logic [ByteW-1:0] expected_val;

    // reader state
    int unsigned      tick_cnt;
    logic [ByteW-1:0] shift_reg;
    logic [ByteW-1:0] seen_cnt;
    logic             all_equal;

    task automatic begin_byte(input logic lvl);
        reader_phase = PH_READ;
        shift_reg    = {{(ByteW-1){1'b0}}, lvl};
        reader_bit   = BitIdxW'(1);
        tick_cnt     = 0;
    endtask

    task automatic advance_reader(input logic lvl);
        tick_result_t r;
        r      = '0;
        r.txct = (reader_phase != PH_CHARGE);
        case (reader_phase)
            PH_INIT:
            begin
                tick_cnt++;
                if (tick_cnt >= init_lim)
                begin
                    reader_phase = PH_CHARGE;
                    tick_cnt     = 0;
                end
            end
            PH_START:
            begin
                if (lvl)
                begin
                    seen_cnt  = '0;
                    all_equal = 1'b1;
                    begin_byte(lvl);
                end
                else
                begin
                    tick_cnt++;
                    if (tick_cnt >= start_lim)
                    begin
                        reader_phase = PH_CHARGE;
                        tick_cnt     = 0;
                    end
                end
            end
            PH_READ:
            begin
                tick_cnt++;
                if (tick_cnt >= bit_lim)
                begin
                    tick_cnt = 0;
                    if (reader_bit < BITS_PER_BYTE)
                    begin
                        // samples beyond the byte width are dropped
                        if (reader_bit < ByteW && lvl)
                            shift_reg[reader_bit[2:0]] = 1'b1;
                        reader_bit++;
                    end
                    else
                    begin
                        r.strobe = 1'b1;
                        r.value  = shift_reg;
                        if (seen_cnt != 8'hFF)
                            seen_cnt++;
                        if (shift_reg != expected_val)
                            all_equal = 1'b0;
                        reader_phase = PH_GAP;
                        reader_bit   = '0;
                    end
                end
            end
            PH_GAP:
            begin
                if (lvl)
                    begin_byte(lvl);
                else
                begin
                    tick_cnt++;
                    if (tick_cnt >= gap_lim)
                    begin
                        r.done       = 1'b1;
                        r.auth       = all_equal;
                        reader_phase = PH_CHARGE;
                        tick_cnt     = 0;
                    end
                end
            end
            default:
            begin
                reader_phase = PH_CHARGE;
                tick_cnt++;
                if (tick_cnt >= charge_lim)
                begin
                    reader_phase = PH_START;
                    tick_cnt     = 0;
                end
            end
        endcase

        r.count = seen_cnt;
        if (r.done)
        begin
            seen_cnt  = '0;
            all_equal = 1'b1;
        end
        else if (reader_phase inside {PH_CHARGE, PH_INIT, PH_START})
            r.count = '0;
        tick_results.push_back(r);
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_lim          = 32'(INIT_TICKS_RST);
            charge_lim        = 32'(CHARGE_TICKS_RST);
            start_lim         = 32'(START_TICKS_RST);
            bit_lim           = 32'(BIT_TICKS_RST);
            gap_lim           = 32'(GAP_TICKS_RST);
            expected_val      = EXPECTED_RST;
            reader_phase      = PH_INIT;
            reader_bit        = '0;
            tick_cnt          = 0;
            shift_reg         = '0;
            seen_cnt          = '0;
            all_equal         = 1'b1;
            tick_results.delete();
            mismatches        = 0;
            pending_results   = 0;
            ticks_checked     = 0;
            bytes_read        = 0;
            frames_closed     = 0;
            frames_authorized = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_INIT_TICKS:   init_lim     = 32'(cfg_data);
                    CFG_CHARGE_TICKS: charge_lim   = 32'(cfg_data);
                    CFG_START_TICKS:  start_lim    = 32'(cfg_data);
                    CFG_BIT_TICKS:    bit_lim      = 32'(cfg_data[BitTickW-1:0]);
                    CFG_GAP_TICKS:    gap_lim      = 32'(cfg_data);
                    CFG_EXPECTED:     expected_val = cfg_data[ByteW-1:0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (tick_results.size() == 0)
                begin
                    $error("result item with no input item outstanding");
                    mismatches++;
                end
                else
                begin
                    want = tick_results.pop_front();
                    check_field("txct_level", want.txct, txct_level);
                    check_field("byte_valid", want.strobe, byte_valid);
                    check_field("byte_value", want.value, byte_value);
                    check_field("frame_done", want.done, frame_done);
                    check_field("auth_ok", want.auth, auth_ok);
                    check_field("byte_count", want.count, byte_count);
                    ticks_checked++;
                    if (want.strobe)
                        bytes_read++;
                    if (want.done)
                    begin
                        frames_closed++;
                        if (want.auth)
                            frames_authorized++;
                    end
                end
            end

            if (in_valid && in_ready)
                advance_reader(line_level);

            pending_results = tick_results.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    import tcrc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // index outside the register map, writes to it must have no effect
    localparam logic [CfgIdxW-1:0] NO_SUCH_REG = 3'd7;

    // directed levels, sent from the top bit down: start timeout, a byte of all ones,
    // a byte of 0x01, then a gap timeout
    localparam logic [22:0] DIRECTED_LEVELS = 23'b0000_1111_1111_0100_0000_000;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic                line_level;
    logic                out_valid;
    logic                out_ready;
    logic                txct_level;
    logic                byte_valid;
    logic [ByteW-1:0]    byte_value;
    logic                frame_done;
    logic                auth_ok;
    logic [ByteW-1:0]    byte_count;

    int                  mismatches;
    int                  pending_results;
    phase_t              reader_phase;
    logic [BitIdxW-1:0]  reader_bit;
    int                  ticks_checked;
    int                  bytes_read;
    int                  frames_closed;
    int                  frames_authorized;

    idle_mode_t          mode;
    int                  start_pct;
    int                  cont_pct;
    int                  noise_pct;
    logic [ByteW-1:0]    expected_now;
    logic [ByteW-1:0]    target_byte;

    transponder_charge_read_controller_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .line_level (line_level),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .txct_level (txct_level),
        .byte_valid (byte_valid),
        .byte_value (byte_value),
        .frame_done (frame_done),
        .auth_ok    (auth_ok),
        .byte_count (byte_count)
    );

    tcrc_scoreboard u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .line_level        (line_level),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .txct_level        (txct_level),
        .byte_valid        (byte_valid),
        .byte_value        (byte_value),
        .frame_done        (frame_done),
        .auth_ok           (auth_ok),
        .byte_count        (byte_count),
        .mismatches        (mismatches),
        .pending_results   (pending_results),
        .reader_phase      (reader_phase),
        .reader_bit        (reader_bit),
        .ticks_checked     (ticks_checked),
        .bytes_read        (bytes_read),
        .frames_closed     (frames_closed),
        .frames_authorized (frames_authorized)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // receiver side
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode == IDLE_RECV)
                out_ready <= ($urandom_range(0, 99) >= 61);
            else if (mode == IDLE_BOTH)
                out_ready <= ($urandom_range(0, 99) >= 38);
            else
                out_ready <= 1'b1;
        end
    end

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    task automatic set_config(input logic [23:0] init_v, input logic [23:0] charge_v,
                              input logic [23:0] start_v, input logic [15:0] bit_v,
                              input logic [23:0] gap_v, input logic [7:0] exp_v);
        wait_idle();
        write_reg(CFG_INIT_TICKS, init_v);
        write_reg(CFG_CHARGE_TICKS, charge_v);
        write_reg(CFG_START_TICKS, start_v);
        write_reg(CFG_BIT_TICKS, CfgDataW'(bit_v));
        write_reg(CFG_GAP_TICKS, gap_v);
        write_reg(CFG_EXPECTED, CfgDataW'(exp_v));
        cfg_wr_en    <= 1'b0;
        expected_now = exp_v;
    endtask

    // called at a falling edge; returns there once the item is taken
    task automatic send_level(input logic lvl);
        int gap_pct;
        gap_pct = (mode == IDLE_SEND) ? 61 : (mode == IDLE_BOTH) ? 38 : 0;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < gap_pct);
        end
        in_valid   <= 1'b1;
        line_level <= lvl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // mostly well-formed line activity, steered by the predicted reader phase
    function automatic logic pick_level();
        if ($urandom_range(0, 99) < noise_pct)
            return logic'($urandom_range(0, 1));
        case (reader_phase)
            PH_START, PH_GAP:
            begin
                target_byte = $urandom_range(0, 1) ? expected_now : ByteW'($urandom);
                return $urandom_range(0, 99) < ((reader_phase == PH_START) ? start_pct
                                                                           : cont_pct);
            end
            PH_READ:
                return (reader_bit < ByteW) ? target_byte[reader_bit[2:0]]
                                            : logic'($urandom_range(0, 1));
            default:
                return logic'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic run_phase(input idle_mode_t m, input int s_pct, input int c_pct,
                             input int n_pct, input int n_items, input int hold_at);
        mode      = m;
        start_pct = s_pct;
        cont_pct  = c_pct;
        noise_pct = n_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (i == hold_at)
                wait_idle();
            send_level(pick_level());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        line_level   = 1'b0;
        mode         = IDLE_NONE;
        start_pct    = 0;
        cont_pct     = 0;
        noise_pct    = 0;
        expected_now = EXPECTED_RST;
        target_byte  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: zero limits, one-tick init, start timeout, two bytes, gap timeout
        write_reg(NO_SUCH_REG, '1);
        set_config(24'd0, 24'd0, 24'd1, 16'd0, 24'd0, 8'hFF);
        for (int i = 22; i >= 0; i--)
            send_level(DIRECTED_LEVELS[i]);

        set_config(24'hFFFFFF, 24'($urandom_range(1, 4)), 24'($urandom_range(2, 6)),
                   16'($urandom_range(1, 3)), 24'($urandom_range(2, 8)),
                   8'($urandom) | 8'h01);
        run_phase(IDLE_NONE, 30, 50, 5, 250, -1);

        set_config(24'd5, 24'd1, 24'd1, 16'd1, 24'd1, 8'h00);
        run_phase(IDLE_SEND, 60, 60, 10, 250, -1);

        set_config(24'd7, 24'($urandom_range(3, 8)), 24'($urandom_range(10, 30)),
                   16'($urandom_range(2, 4)), 24'($urandom_range(5, 15)), 8'hFF);
        run_phase(IDLE_RECV, 20, 35, 5, 300, 150);

        // all limits but init at maximum: the reader sits in whatever phase it is in
        set_config(24'd1, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 8'($urandom));
        run_phase(IDLE_BOTH, 0, 0, 0, 60, -1);

        // limits drop below the running count, the waiting phase ends at once
        set_config(24'd2, 24'd2, 24'($urandom_range(1, 5)), 16'($urandom_range(1, 4)),
                   24'd3, 8'($urandom) | 8'h01);
        run_phase(IDLE_BOTH, 15, 40, 10, 300, -1);

        // one long frame of back to back bytes
        set_config(24'd3, 24'd1, 24'd8, 16'd1, 24'hFFFFFF, 8'($urandom));
        run_phase(IDLE_NONE, 100, 100, 0, 450, -1);

        set_config(24'd4, 24'($urandom_range(1, 3)), 24'($urandom_range(2, 6)), 16'd2,
                   24'd2, 8'($urandom) | 8'h01);
        run_phase(IDLE_SEND, 40, 25, 5, 220, -1);

        wait_idle();
        repeat (4) @(posedge clk);

        $display("checked %0d tick results; %0d bytes read, %0d frames closed (%0d authorized)",
                 ticks_checked, bytes_read, frames_closed, frames_authorized);
        $display("covered zero and maximum limits, start and gap timeouts, long frames, stalls");
        if (mismatches == 0 && pending_results == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
